@@ rtl/base64_stream_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// Base64 stream encoder assertion macros
// Shared concurrent assertion wrappers, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Property holds at every edge outside reset.
`define B64E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/b64e_pkg.sv @@
// ----------------------------------------------------------------------------
// Base64 stream encoder package
// Transaction types, queue job format, alphabet constants and digit mapping.
// ----------------------------------------------------------------------------
package b64e_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;
  } out_item_t;

  // One output symbol: a six-bit digit or a pad character
  typedef struct packed {
    logic       is_pad;
    logic [5:0] digit;
  } sym_t;

  // Everything one input byte produces: up to four symbols
  typedef struct packed {
    sym_t [3:0] syms;
    logic [1:0] last_idx;
    logic       msg_last;
  } job_t;

  typedef struct packed {
    logic url_alphabet;
    logic omit_padding;
  } cfg_t;

  localparam logic CFG_URL_ALPHABET = 1'b0;
  localparam logic CFG_OMIT_PADDING = 1'b1;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;  // '='
  localparam logic [7:0] STD_CHAR_62  = 8'h2B;  // '+'
  localparam logic [7:0] STD_CHAR_63  = 8'h2F;  // '/'
  localparam logic [7:0] URL_CHAR_62  = 8'h2D;  // '-'
  localparam logic [7:0] URL_CHAR_63  = 8'h5F;  // '_'
  localparam logic [7:0] UPPER_BASE   = 8'h41;  // 'A' - 0
  localparam logic [7:0] LOWER_BASE   = 8'h47;  // 'a' - 26
  localparam logic [7:0] NUMERAL_BASE = 8'hFC;  // '0' - 52, modulo 256

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic url);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d < 6'd26) begin
      digit_char = d8 + UPPER_BASE;
    end else if (d < 6'd52) begin
      digit_char = d8 + LOWER_BASE;
    end else if (d < 6'd62) begin
      digit_char = d8 + NUMERAL_BASE;
    end else if (d == 6'd62) begin
      digit_char = url ? URL_CHAR_62 : STD_CHAR_62;
    end else begin
      digit_char = url ? URL_CHAR_63 : STD_CHAR_63;
    end
  endfunction

endpackage

@@ rtl/b64e_front.sv @@
// ----------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, tracks the group position and leftover bits, and builds one
// queue job per byte holding its digits and any padding.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_macros.svh"

module b64e_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  b64e_pkg::in_item_t in_data,
  input  logic               omit_padding,
  input  logic               q_full,
  output logic               push,
  output b64e_pkg::job_t     push_job
);

  localparam logic [1:0] POS_0 = 2'd0;
  localparam logic [1:0] POS_1 = 2'd1;
  localparam logic [1:0] POS_2 = 2'd2;

  logic [1:0] pos_r, pos_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [7:0] b;
  logic       last;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign b        = in_data.data_byte;
  assign last     = in_data.message_last;

  always_comb begin
    push_job          = '0;
    push_job.msg_last = last;
    pos_nxt           = pos_r;
    carry_nxt         = carry_r;
    unique case (pos_r)
      POS_1: begin
        push_job.syms[0].digit = {carry_r[1:0], b[7:4]};
        push_job.syms[1].digit = {b[3:0], 2'b00};
        push_job.syms[2].is_pad = 1'b1;
        if (!last) begin
          push_job.last_idx = 2'd0;
        end else if (omit_padding) begin
          push_job.last_idx = 2'd1;
        end else begin
          push_job.last_idx = 2'd2;
        end
        pos_nxt   = POS_2;
        carry_nxt = b[3:0];
      end
      POS_2: begin
        push_job.syms[0].digit = {carry_r, b[7:6]};
        push_job.syms[1].digit = b[5:0];
        push_job.last_idx      = 2'd1;
        pos_nxt   = POS_0;
        carry_nxt = 4'd0;
      end
      default: begin
        // group start; the unused position behaves the same
        push_job.syms[0].digit  = b[7:2];
        push_job.syms[1].digit  = {b[1:0], 4'b0000};
        push_job.syms[2].is_pad = 1'b1;
        push_job.syms[3].is_pad = 1'b1;
        if (!last) begin
          push_job.last_idx = 2'd0;
        end else if (omit_padding) begin
          push_job.last_idx = 2'd1;
        end else begin
          push_job.last_idx = 2'd3;
        end
        pos_nxt   = POS_1;
        carry_nxt = {2'b00, b[1:0]};
      end
    endcase
    // a final byte closes the group
    if (last) begin
      pos_nxt   = POS_0;
      carry_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_0;
      carry_r <= 4'd0;
    end else if (push) begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
    end
  end

  `B64E_ASSERT(a_carry_clear_at_start, (pos_r == POS_0) |-> (carry_r == 4'd0), "carry bits left at group start")
  `B64E_ASSERT_NEXT(a_last_restarts_group, push && last, pos_r == POS_0, "final byte did not restart group")
  `B64E_ASSERT(a_final_has_flush, (push && last) |-> (push_job.last_idx != 2'd0), "final byte without flush")

endmodule

@@ rtl/b64e_queue.sv @@
// ----------------------------------------------------------------------------
// Base64 encoder job queue
// Short register queue between front and back end, one push and one pop a
// cycle, head visible without latency.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_macros.svh"

module b64e_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output b64e_pkg::job_t head,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64e_pkg::job_t entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  `B64E_ASSERT(a_no_overflow, push |-> !full, "push into full queue")
  `B64E_ASSERT(a_no_underflow, pop |-> !empty, "pop from empty queue")
  `B64E_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "queue count out of range")

endmodule

@@ rtl/b64e_back.sv @@
// ----------------------------------------------------------------------------
// Base64 encoder back end
// Takes jobs from the queue and emits their characters one a cycle, while the
// output is not stalled and jobs are waiting, through a registered output stage.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_macros.svh"

module b64e_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                url_alphabet,
  input  logic                q_empty,
  input  b64e_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output b64e_pkg::out_item_t out_data
);

  logic                cur_valid_r, cur_valid_nxt;
  b64e_pkg::job_t      cur_job_r;
  logic [1:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  b64e_pkg::out_item_t out_data_r, out_data_nxt;
  b64e_pkg::sym_t      sym;
  logic                out_free;
  logic                emit;
  logic                done;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sym      = cur_job_r.syms[idx_r];
    out_free = !out_valid_r || !out_stall;
    emit     = out_free && cur_valid_r;
    done     = emit && (idx_r == cur_job_r.last_idx);
    // refill when no job is held, or as the current job hands over its final character
    q_pop    = !q_empty && (!cur_valid_r || done);

    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 1'b1;
    end

    out_valid_nxt = out_free ? emit : out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_data_nxt.out_char    = sym.is_pad ? b64e_pkg::PAD_CHAR
                                            : b64e_pkg::digit_char(sym.digit, url_alphabet);
      out_data_nxt.run_last    = (idx_r == cur_job_r.last_idx);
      out_data_nxt.message_end = (idx_r == cur_job_r.last_idx) && cur_job_r.msg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_job_r <= q_head;
    end
    out_data_r <= out_data_nxt;
  end

  `B64E_ASSERT(a_end_on_run_last, (out_valid_r && out_data_r.message_end) |-> out_data_r.run_last, "message end off run boundary")
  `B64E_ASSERT(a_idx_in_job, cur_valid_r |-> (idx_r <= cur_job_r.last_idx), "symbol index past job end")
  `B64E_ASSERT_NEXT(a_pop_loads_job, q_pop, cur_valid_r && (idx_r == 2'd0), "popped job not loaded")

endmodule

@@ rtl/base64_stream_encoder.sv @@
// A byte's job crosses the job queue, current-job register and output register in turn.
// Throughput: the back end emits one character a cycle unless stalled; a byte
// yields 1 or 2 characters (4 per 3 bytes), a final byte up to 4 with flush and padding.
// Input takes one byte a cycle until the QUEUE_DEPTH job queue fills.
// Reset (synchronous, rst_n low): group restarts, queue and output empty, config to 0.
// ----------------------------------------------------------------------------
// Base64 stream encoder
// Byte stream to Base64 characters, standard or URL-safe alphabet, optional
// padding; front end classifies bytes, back end emits characters.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64e_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output b64e_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_wdata
);

  b64e_pkg::cfg_t cfg_r, cfg_nxt;
  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           q_pop;
  b64e_pkg::job_t push_job;
  b64e_pkg::job_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        b64e_pkg::CFG_URL_ALPHABET: cfg_nxt.url_alphabet = cfg_wdata;
        b64e_pkg::CFG_OMIT_PADDING: cfg_nxt.omit_padding = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .omit_padding (cfg_r.omit_padding),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  b64e_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .url_alphabet (cfg_r.url_alphabet),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

@@ dv/tb_base64_stream_encoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Base64 stream encoder testbench
// Walks a short table of directed bytes, then sends random messages under
// each alphabet and padding setting. Every character is checked against a
// cycle-free encoder model or a row's typed characters, with random idling outside the closing phase.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;

  localparam int HOLD_CYCLES      = 200;
  localparam int RANDOM_PER_PHASE = 45;
  localparam int SETTLE_CYCLES    = 4;

  // One directed row: setting, byte, and the characters where they are obvious
  typedef struct packed {
    logic        url;
    logic        omit;
    logic [7:0]  data_byte;
    logic        message_last;
    logic [2:0]  n_typed;
    logic [31:0] typed;
  } stim_row_t;

  // Hand-typed characters for one byte, right-aligned; n of zero means none
  typedef struct packed {
    logic [2:0]  n;
    logic [31:0] chars;
  } glance_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  b64e_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  b64e_pkg::out_item_t out_data;
  logic                cfg_we;
  logic                cfg_index;
  logic                cfg_wdata;

  string std_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string url_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  // Encoder model state and its copy of the registers
  logic       model_url;
  logic       model_omit;
  logic [1:0] model_pos;
  logic [3:0] model_carry;

  // Setting last written by the sender
  logic drv_url;
  logic drv_omit;

  b64e_pkg::out_item_t expected_chars[$];
  glance_t             glance_chars[$];
  stim_row_t           directed_rows[$];
  int                  mismatches;
  bit                  sink_idles;
  bit                  sender_idles;
  bit                  hold_request;

  base64_stream_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("base64_stream_encoder regression: fail");
    $finish;
  end

  function automatic logic [7:0] b64_symbol(input logic [5:0] d);
    if (model_url) begin
      return url_set[d];
    end
    return std_set[d];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t mismatch: %s got 'h%0h want 'h%0h", $time, what, got, want);
    end
  endtask

  // Work out the characters one byte causes and queue them
  task automatic predict_chars(input b64e_pkg::in_item_t item, input glance_t glance);
    logic [7:0]          ch [4];
    logic [7:0]          b;
    int                  n;
    b64e_pkg::out_item_t res;
    b = item.data_byte;
    n = 0;
    case (model_pos)
      2'd1: begin
        ch[n] = b64_symbol({model_carry[1:0], b[7:4]});
        n++;
        model_carry = b[3:0];
        model_pos   = 2'd2;
        if (item.message_last) begin
          ch[n] = b64_symbol({b[3:0], 2'b00});
          n++;
          if (!model_omit) begin
            ch[n] = b64e_pkg::PAD_CHAR;
            n++;
          end
        end
      end
      2'd2: begin
        ch[n] = b64_symbol({model_carry, b[7:6]});
        n++;
        ch[n] = b64_symbol(b[5:0]);
        n++;
        model_carry = 4'd0;
        model_pos   = 2'd0;
      end
      default: begin
        ch[n] = b64_symbol(b[7:2]);
        n++;
        model_carry = {2'b00, b[1:0]};
        model_pos   = 2'd1;
        if (item.message_last) begin
          ch[n] = b64_symbol({b[1:0], 4'b0000});
          n++;
          if (!model_omit) begin
            ch[n] = b64e_pkg::PAD_CHAR;
            n++;
            ch[n] = b64e_pkg::PAD_CHAR;
            n++;
          end
        end
      end
    endcase
    if (item.message_last) begin
      model_pos   = 2'd0;
      model_carry = 4'd0;
    end
    // Typed characters replace the model's where the row carries them
    if (glance.n != 0) begin
      n = glance.n;
      for (int k = 0; k < n; k++) begin
        ch[k] = glance.chars[8 * (n - 1 - k) +: 8];
      end
    end
    for (int k = 0; k < n; k++) begin
      res.out_char    = ch[k];
      res.run_last    = (k == n - 1);
      res.message_end = (k == n - 1) && item.message_last;
      expected_chars.push_back(res);
    end
  endtask

  always @(posedge clk) begin : monitor
    b64e_pkg::out_item_t want;
    glance_t             glance;
    if (!rst_n) begin
      model_url   = 1'b0;
      model_omit  = 1'b0;
      model_pos   = 2'd0;
      model_carry = 4'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          b64e_pkg::CFG_URL_ALPHABET: model_url  = cfg_wdata;
          b64e_pkg::CFG_OMIT_PADDING: model_omit = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        glance = '0;
        if (glance_chars.size() != 0) begin
          glance = glance_chars.pop_front();
        end
        predict_chars(in_data, glance);
      end
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("character with none expected", out_data.out_char, 0);
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            report_mismatch("out_char", out_data.out_char, want.out_char);
          end
          if (out_data.run_last !== want.run_last) begin
            report_mismatch("run_last", out_data.run_last, want.run_last);
          end
          if (out_data.message_end !== want.message_end) begin
            report_mismatch("message_end", out_data.message_end, want.message_end);
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off on request
  initial begin : sink
    int span;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall    = 1'b0;
        hold_request = 1'b0;
      end else if (sink_idles && $urandom_range(0, 4) == 0) begin
        span      = $urandom_range(1, 8);
        out_stall = 1'b1;
        repeat (span) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic add_row(input logic url, input logic omit, input logic [7:0] b,
                         input logic last, input int n, input logic [31:0] chars);
    stim_row_t r;
    r.url          = url;
    r.omit         = omit;
    r.data_byte    = b;
    r.message_last = last;
    r.n_typed      = 3'(n);
    r.typed        = chars;
    directed_rows.push_back(r);
  endtask

  function automatic int pick_gap();
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      return $urandom_range(1, 8);
    end
    return 0;
  endfunction

  // Offer one byte and hold it until the transaction completes
  task automatic send_byte(input logic [7:0] b, input logic last, input glance_t g,
                           input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    glance_chars.push_back(g);
    in_data.data_byte    = b;
    in_data.message_last = last;
    in_valid             = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setting(input logic url, input logic omit);
    cfg_we    = 1'b1;
    cfg_index = b64e_pkg::CFG_URL_ALPHABET;
    cfg_wdata = url;
    @(negedge clk);
    cfg_index = b64e_pkg::CFG_OMIT_PADDING;
    cfg_wdata = omit;
    @(negedge clk);
    cfg_we   = 1'b0;
    drv_url  = url;
    drv_omit = omit;
  endtask

  initial begin : stimulus
    stim_row_t r;
    glance_t   g;
    glance_t   none;
    int        sent;
    int        len;
    bit        paused;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = b64e_pkg::CFG_URL_ALPHABET;
    cfg_wdata    = 1'b0;
    rst_n        = 1'b0;
    sink_idles   = 1'b0;
    sender_idles = 1'b0;
    hold_request = 1'b0;
    mismatches   = 0;
    drv_url      = 1'b0;
    drv_omit     = 1'b0;
    none         = '0;
    paused       = 1'b0;

    // url, omit, byte, last, typed count, typed characters
    add_row(0, 0, 8'h00, 1, 4, "AA==");
    add_row(0, 0, 8'hFF, 1, 4, "/w==");
    add_row(0, 0, 8'hFF, 0, 1, "/");
    add_row(0, 0, 8'hFF, 0, 1, "/");
    add_row(0, 0, 8'hFF, 1, 2, "//");
    add_row(0, 0, 8'h00, 0, 1, "A");
    add_row(0, 0, 8'h00, 1, 3, "AA=");
    add_row(0, 0, 8'hFF, 0, 1, "/");
    add_row(0, 0, 8'hFF, 1, 3, "/8=");
    add_row(0, 0, 8'hF8, 1, 0, 0);
    add_row(0, 0, 8'hFC, 0, 0, 0);
    add_row(0, 0, 8'h0F, 0, 0, 0);
    add_row(0, 0, 8'hA5, 1, 0, 0);
    add_row(1, 0, 8'hFF, 1, 4, "_w==");
    add_row(1, 0, 8'hF8, 0, 0, 0);
    add_row(1, 0, 8'h3E, 0, 0, 0);
    add_row(1, 0, 8'hBF, 1, 0, 0);
    add_row(0, 1, 8'h00, 1, 2, "AA");
    add_row(0, 1, 8'hFF, 0, 1, "/");
    add_row(0, 1, 8'hFF, 1, 2, "/8");
    add_row(1, 1, 8'hFB, 1, 0, 0);
    add_row(1, 1, 8'h12, 0, 0, 0);
    add_row(1, 1, 8'h34, 1, 0, 0);

    repeat (6) @(negedge clk);
    rst_n        = 1'b1;
    sink_idles   = 1'b1;
    sender_idles = 1'b1;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.url !== drv_url || r.omit !== drv_omit) begin
        drain();
        apply_setting(r.url, r.omit);
      end
      g.n     = r.n_typed;
      g.chars = r.typed;
      send_byte(r.data_byte, r.message_last, g, pick_gap());
    end

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: apply_setting(1'b1, 1'b0);
        1: apply_setting(1'b0, 1'b1);
        2: apply_setting(1'b1, 1'b1);
        3: apply_setting(1'b0, 1'b0);
        default: apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      // No idling in the closing phase
      sender_idles = (phase < 4);
      sink_idles   = (phase < 4);
      // Hold the receiver off while bytes keep coming, so the queue fills
      if (phase == 1) begin
        hold_request = 1'b1;
      end
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        if (phase == 2 && sent >= 25 && !paused) begin
          drain();
          paused = 1'b1;
        end
        len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
        for (int k = 0; k < len; k++) begin
          send_byte(8'($urandom_range(0, 255)), k == len - 1, none, pick_gap());
          sent++;
        end
      end
    end

    in_valid = 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("base64_stream_encoder regression: pass");
    end else begin
      $display("base64_stream_encoder regression: fail");
    end
    $finish;
  end

endmodule
